@@ rtl/dalsc_pkg.sv @@
// Shared types and constants of the door actuator limit switch controller.
package dalsc_pkg;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECLOSE = 2'd2;

  localparam logic [CFG_W-1:0] GUARD_RESET   = 20'd1000;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 20'd20000;
  localparam logic [CFG_W-1:0] RECLOSE_RESET = 20'd1000;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_OPEN   = 2'd1;
  localparam logic [1:0] CMD_CLOSE  = 2'd2;
  localparam logic [1:0] CMD_INSIDE = 2'd3;

  typedef enum logic [2:0] {
    ST_OPEN    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_FLOAT   = 3'd2,
    ST_ERROR   = 3'd3,
    ST_OPENING = 3'd4,
    ST_CLOSING = 3'd5
  } door_st_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_MOVING    = 3'd1,
    PH_WAIT_OPEN = 3'd2,
    PH_WAIT_SHUT = 3'd3,
    PH_DELAY     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_REFUSED = 3'd2,
    EV_DONE    = 3'd3,
    EV_ABORT   = 3'd4
  } evt_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       limit_open;
    logic       limit_close;
    logic       reed_shut;
    logic       move_enable;
  } item_t;

  typedef struct packed {
    door_st_t door_status;
    phase_t   phase;
    logic     move_direction;
    logic     sequence_active;
  } ctrl_t;

  typedef struct packed {
    logic     drive_open;
    logic     drive_close;
    door_st_t door_state;
    logic     busy;
    evt_t     event_code;
  } result_t;

endpackage

@@ rtl/dalsc_in_stage.sv @@
// Input register stage holding one accepted tick.
module dalsc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dalsc_pkg::item_t  item_in,
  input  logic              advance,
  output logic              item_valid,
  output dalsc_pkg::item_t  item_q
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_q <= item_in;
    end
  end

endmodule

@@ rtl/dalsc_step.sv @@
// Per-tick next-state and result logic of the motor controller.
module dalsc_step #(
  parameter int COUNT_WIDTH = 20
) (
  input  dalsc_pkg::item_t               item,
  input  dalsc_pkg::ctrl_t               ctrl,
  input  logic [COUNT_WIDTH-1:0]         elapsed,
  input  logic [dalsc_pkg::CFG_W-1:0]    guard_ticks,
  input  logic [dalsc_pkg::CFG_W-1:0]    timeout_ticks,
  input  logic [dalsc_pkg::CFG_W-1:0]    reclose_delay_ticks,
  output dalsc_pkg::ctrl_t               ctrl_next,
  output logic [COUNT_WIDTH-1:0]         elapsed_next,
  output dalsc_pkg::result_t             res
);

  localparam int CMP_W = (COUNT_WIDTH > dalsc_pkg::CFG_W) ? COUNT_WIDTH : dalsc_pkg::CFG_W;

  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [CMP_W-1:0]       elapsed_x;
  logic [CMP_W-1:0]       elapsed_inc_x;
  logic [CMP_W-1:0]       guard_x;
  logic [CMP_W-1:0]       timeout_x;
  logic [CMP_W-1:0]       reclose_x;
  dalsc_pkg::door_st_t    cur;
  dalsc_pkg::door_st_t    target_st;
  dalsc_pkg::door_st_t    start_st;
  dalsc_pkg::evt_t        ev;
  logic                   abort_now;
  logic                   start_req;
  logic                   start_dir;
  logic                   start_seq;
  logic                   start_ok;

  assign elapsed_inc   = (elapsed == {COUNT_WIDTH{1'b1}}) ? elapsed :
                         elapsed + COUNT_WIDTH'(1);
  assign elapsed_x     = CMP_W'(elapsed);
  assign elapsed_inc_x = CMP_W'(elapsed_inc);
  assign guard_x       = CMP_W'(guard_ticks);
  assign timeout_x     = CMP_W'(timeout_ticks);
  assign reclose_x     = CMP_W'(reclose_delay_ticks);

  always_comb begin
    if (item.limit_open && !item.limit_close) begin
      cur = dalsc_pkg::ST_OPEN;
    end else if (item.limit_close && !item.limit_open) begin
      cur = dalsc_pkg::ST_CLOSED;
    end else if (!item.limit_open && !item.limit_close) begin
      cur = dalsc_pkg::ST_FLOAT;
    end else begin
      cur = dalsc_pkg::ST_ERROR;
    end
  end

  assign target_st = ctrl.move_direction ? dalsc_pkg::ST_CLOSED : dalsc_pkg::ST_OPEN;
  assign start_st  = ctrl.move_direction ? dalsc_pkg::ST_OPEN : dalsc_pkg::ST_CLOSED;

  always_comb begin
    ctrl_next       = ctrl;
    elapsed_next    = elapsed;
    res.drive_open  = 1'b0;
    res.drive_close = 1'b0;
    abort_now       = 1'b0;
    start_req       = 1'b0;
    start_dir       = 1'b0;
    start_seq       = 1'b0;
    start_ok        = 1'b0;
    ev = (ctrl.phase != dalsc_pkg::PH_IDLE && item.cmd != dalsc_pkg::CMD_TICK) ?
         dalsc_pkg::EV_REFUSED : dalsc_pkg::EV_NONE;

    case (ctrl.phase)
      dalsc_pkg::PH_MOVING: begin
        elapsed_next = elapsed_inc;
        if (!item.move_enable) begin
          abort_now = 1'b1;
        end else if (cur == target_st) begin
          ctrl_next.door_status = target_st;
          ev = dalsc_pkg::EV_DONE;
          if (ctrl.sequence_active && !ctrl.move_direction) begin
            ctrl_next.phase = dalsc_pkg::PH_WAIT_OPEN;
          end else begin
            ctrl_next.phase           = dalsc_pkg::PH_IDLE;
            ctrl_next.sequence_active = 1'b0;
          end
        end else if ((elapsed_inc_x > guard_x && cur == start_st) ||
                     elapsed_inc_x > timeout_x) begin
          abort_now = 1'b1;
        end else begin
          res.drive_open  = !ctrl.move_direction;
          res.drive_close = ctrl.move_direction;
        end
        if (abort_now) begin
          ctrl_next.door_status     = dalsc_pkg::ST_FLOAT;
          ctrl_next.phase           = dalsc_pkg::PH_IDLE;
          ctrl_next.sequence_active = 1'b0;
          ev = dalsc_pkg::EV_ABORT;
        end
      end
      dalsc_pkg::PH_WAIT_OPEN: begin
        if (!item.reed_shut) begin
          ctrl_next.phase = dalsc_pkg::PH_WAIT_SHUT;
        end
      end
      dalsc_pkg::PH_WAIT_SHUT: begin
        if (item.reed_shut) begin
          ctrl_next.phase = dalsc_pkg::PH_DELAY;
          elapsed_next    = '0;
        end
      end
      dalsc_pkg::PH_DELAY: begin
        if (elapsed_x >= reclose_x) begin
          ctrl_next.phase           = dalsc_pkg::PH_IDLE;
          ctrl_next.sequence_active = 1'b0;
          start_req                 = 1'b1;
          start_dir                 = 1'b1;
        end else begin
          elapsed_next = elapsed_inc;
        end
      end
      default: begin
        ctrl_next.phase           = dalsc_pkg::PH_IDLE;
        ctrl_next.sequence_active = 1'b0;
        ctrl_next.door_status     = cur;
        if (item.cmd == dalsc_pkg::CMD_OPEN || item.cmd == dalsc_pkg::CMD_CLOSE) begin
          start_req = 1'b1;
          start_dir = (item.cmd == dalsc_pkg::CMD_CLOSE);
        end else if (item.cmd == dalsc_pkg::CMD_INSIDE) begin
          start_req = 1'b1;
          if (cur == dalsc_pkg::ST_OPEN && item.reed_shut) begin
            start_dir = 1'b1;
          end else begin
            start_seq = 1'b1;
          end
        end
      end
    endcase

    start_ok = item.reed_shut && item.move_enable &&
               (cur != (start_dir ? dalsc_pkg::ST_CLOSED : dalsc_pkg::ST_OPEN));
    if (start_req) begin
      if (start_ok) begin
        ctrl_next.phase           = dalsc_pkg::PH_MOVING;
        ctrl_next.move_direction  = start_dir;
        ctrl_next.sequence_active = start_seq;
        ctrl_next.door_status     = start_dir ? dalsc_pkg::ST_CLOSING : dalsc_pkg::ST_OPENING;
        elapsed_next              = '0;
        res.drive_open            = !start_dir;
        res.drive_close           = start_dir;
        ev = dalsc_pkg::EV_START;
      end else begin
        ev = dalsc_pkg::EV_REFUSED;
      end
    end

    res.door_state = ctrl_next.door_status;
    res.busy       = (ctrl_next.phase != dalsc_pkg::PH_IDLE);
    res.event_code = ev;
  end

endmodule

@@ rtl/door_actuator_limit_switch_controller_top.sv @@
// Top level of the door actuator limit switch controller.
// Usage:
//   Input channel (in_valid / in_stall) carries one sampled tick: cmd, both
//   limit switches, reed switch and move enable. A transfer happens when
//   in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   tick: bridge leg drives, door state, busy flag and event code.
//   Configuration channel (cfg_valid / cfg_ready) writes guard, timeout and
//   reclose delay by index; cfg_ready is always high. Write only when idle.
// Timing:
//   One tick per cycle sustained while out_stall is low. Each accepted tick
//   is loaded into the input register, then passes through the step logic
//   into the result register, which offers it on the output channel.
// Reset: synchronous; door status floating, phase idle, counter cleared,
//   registers back to their defaults, both channels empty.
// Stall: a stalled result holds; if the input register is empty, one more
//   tick is taken into it, after which in_stall rises until the result moves on.
module door_actuator_limit_switch_controller_top #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        cmd,
  input  logic                              limit_open,
  input  logic                              limit_close,
  input  logic                              reed_shut,
  input  logic                              move_enable,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              drive_open,
  output logic                              drive_close,
  output logic [2:0]                        door_state,
  output logic                              busy_res,
  output logic [2:0]                        event_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dalsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dalsc_pkg::CFG_W-1:0]       cfg_data
);

  dalsc_pkg::item_t            item_in;
  dalsc_pkg::item_t            item_q;
  logic                        item_valid;
  logic                        advance;
  dalsc_pkg::ctrl_t            ctrl;
  dalsc_pkg::ctrl_t            ctrl_next;
  logic [COUNT_WIDTH-1:0]      elapsed;
  logic [COUNT_WIDTH-1:0]      elapsed_next;
  logic [dalsc_pkg::CFG_W-1:0] guard_ticks;
  logic [dalsc_pkg::CFG_W-1:0] timeout_ticks;
  logic [dalsc_pkg::CFG_W-1:0] reclose_delay_ticks;
  dalsc_pkg::result_t          res;
  dalsc_pkg::result_t          result;

  assign item_in.cmd         = cmd;
  assign item_in.limit_open  = limit_open;
  assign item_in.limit_close = limit_close;
  assign item_in.reed_shut   = reed_shut;
  assign item_in.move_enable = move_enable;

  assign advance   = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  dalsc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  dalsc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .item                (item_q),
    .ctrl                (ctrl),
    .elapsed             (elapsed),
    .guard_ticks         (guard_ticks),
    .timeout_ticks       (timeout_ticks),
    .reclose_delay_ticks (reclose_delay_ticks),
    .ctrl_next           (ctrl_next),
    .elapsed_next        (elapsed_next),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_ticks         <= dalsc_pkg::GUARD_RESET;
      timeout_ticks       <= dalsc_pkg::TIMEOUT_RESET;
      reclose_delay_ticks <= dalsc_pkg::RECLOSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dalsc_pkg::CFG_GUARD:   guard_ticks         <= cfg_data;
        dalsc_pkg::CFG_TIMEOUT: timeout_ticks       <= cfg_data;
        dalsc_pkg::CFG_RECLOSE: reclose_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.door_status     <= dalsc_pkg::ST_FLOAT;
      ctrl.phase           <= dalsc_pkg::PH_IDLE;
      ctrl.move_direction  <= 1'b0;
      ctrl.sequence_active <= 1'b0;
      elapsed              <= '0;
      out_valid            <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        ctrl    <= ctrl_next;
        elapsed <= elapsed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= res;
    end
  end

  assign drive_open  = result.drive_open;
  assign drive_close = result.drive_close;
  assign door_state  = result.door_state;
  assign busy_res    = result.busy;
  assign event_res   = result.event_code;

`ifndef ASSERT_OFF
  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_open && drive_close))
    else $error("both bridge legs driven");

  a_drive_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (drive_open || drive_close)) |->
    (door_state == dalsc_pkg::ST_OPENING || door_state == dalsc_pkg::ST_CLOSING))
    else $error("leg driven outside a move");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == dalsc_pkg::EV_START) |-> busy_res)
    else $error("move started without busy");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with result path free");
`endif

endmodule
